// ----- src/sfir_pkg.sv -----
// ----------------------------------------------------------------------------
// Stereo symmetric FIR package
// Sizes, sample and control types, and the coefficient table, which is built
// from a windowed sinc at elaboration.
// ----------------------------------------------------------------------------
package sfir_pkg;

  localparam int HALF_TAPS   = 128;
  localparam int FS_HZ       = 192000;
  localparam int CUTOFF_HZ   = 24000;
  localparam int COEF_BITS   = 16;

  localparam int FRAC     = COEF_BITS - 1;
  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = (HALF_TAPS > 2) ? $clog2(HALF_TAPS) : 1;
  localparam int PAIR_W   = SAMPLE_W + 1;
  localparam int PROD_W   = PAIR_W + COEF_BITS;
  localparam int ACC_W    = PROD_W + CNT_W + 1;

  localparam longint unsigned FS_HZ_X2 = 2 * FS_HZ;
  localparam longint unsigned TWO_HALF = 2 * HALF_TAPS;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC - 1);
  localparam logic signed [ACC_W-1:0] OUT_MAX  = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] OUT_MIN  = -ACC_W'(32768);

  typedef logic signed [SAMPLE_W-1:0]  sample_w_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef coef_t                       coef_rom_t [HALF_TAPS];

  typedef struct packed {
    sample_w_t left;
    sample_w_t right;
  } sample_t;

  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic en;
  } mac_ctrl_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } mac_stat_t;

  // Arctangent of 2^-i in Q32 turns.
  localparam longint ATAN_TURNS [32] = '{
    64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4, 64'sh028B0D43,
    64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55, 64'sh0028BE53, 64'sh00145F2F,
    64'sh000A2F98, 64'sh000517CC, 64'sh00028BE6, 64'sh000145F3, 64'sh0000A2FA,
    64'sh0000517D, 64'sh000028BE, 64'sh0000145F, 64'sh00000A30, 64'sh00000518,
    64'sh0000028C, 64'sh00000146, 64'sh000000A3, 64'sh00000051, 64'sh00000029,
    64'sh00000014, 64'sh0000000A, 64'sh00000005, 64'sh00000003, 64'sh00000001,
    64'sh00000001, 64'sh00000000
  };

  // Round to nearest with halves going up, then shift right.
  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // 32-step rotation in Q32 turns; returns the sine or the cosine in Q30.
  function automatic longint cordic(logic [31:0] a, bit want_sin);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    logic [31:0] aa;
    bit neg;
    x   = 64'sd652032874;
    y   = 64'sd0;
    aa  = a;
    neg = 1'b0;
    if (aa[31:30] == 2'd1 || aa[31:30] == 2'd2) begin
      aa[31] = ~aa[31];
      neg    = 1'b1;
    end
    z = longint'($signed(aa));
    for (int i = 0; i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURNS[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURNS[i];
      end
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    return want_sin ? y : x;
  endfunction

  // One coefficient: windowed sinc at distance k from the centre tap.
  function automatic longint coef_val(int k);
    longint unsigned num;
    longint unsigned ph;
    longint unsigned d;
    longint unsigned mag;
    longint unsigned n;
    longint unsigned rem;
    longint unsigned qv;
    longint s1;
    longint c2;
    longint w;
    longint sw;
    longint p;
    longint val;
    logic [31:0] a1;
    logic [31:0] a2;
    if (k == 0) begin
      num = longint'(CUTOFF_HZ) << (FRAC + 1);
      val = longint'((num + longint'(FS_HZ)) / FS_HZ_X2);
    end else begin
      ph  = (longint'(CUTOFF_HZ) * longint'(k)) % FS_HZ;
      a1  = 32'((ph << 32) / FS_HZ);
      a2  = 32'((longint'(k) << 32) / TWO_HALF);
      s1  = cordic(a1, 1'b1);
      c2  = cordic(a2, 1'b0);
      w   = 64'sd579820585 + round_shift(64'sd493921239 * c2, 30);
      sw  = round_shift(s1 * w, 30);
      p   = sw * 64'sd341782638;
      d   = longint'(k) << (60 - FRAC);
      mag = (p < 0) ? longint'(-p) : longint'(p);
      n   = mag + (d >> 1);
      // Shift-and-subtract quotient.
      rem = '0;
      qv  = '0;
      for (int i = 63; i >= 0; i--) begin
        rem = (rem << 1) | longint'(n[i]);
        if (rem >= d) begin
          rem   = rem - d;
          qv[i] = 1'b1;
        end
      end
      val = (p < 0) ? -longint'(qv) : longint'(qv);
    end
    if (val > (64'sd1 <<< FRAC) - 1) begin
      val = (64'sd1 <<< FRAC) - 1;
    end else if (val < -(64'sd1 <<< FRAC)) begin
      val = -(64'sd1 <<< FRAC);
    end
    return val;
  endfunction

  function automatic coef_rom_t build_rom();
    coef_rom_t r;
    for (int k = 0; k < HALF_TAPS; k++) begin
      r[k] = coef_t'(coef_val(k));
    end
    return r;
  endfunction

  localparam coef_rom_t COEF_ROM = build_rom();

endpackage

// ----- src/sfir_in_if.sv -----
// ----------------------------------------------------------------------------
// Stereo FIR input channel
// Valid/ready channel carrying one left and one right input sample.
// ----------------------------------------------------------------------------
interface sfir_in_if import sfir_pkg::*; ();
  logic      valid;
  logic      ready;
  sample_w_t left_in;
  sample_w_t right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

// ----- src/sfir_out_if.sv -----
// ----------------------------------------------------------------------------
// Stereo FIR output channel
// Valid/ready channel carrying one filtered left and right sample.
// ----------------------------------------------------------------------------
interface sfir_out_if import sfir_pkg::*; ();
  logic      valid;
  logic      ready;
  sample_w_t left_out;
  sample_w_t right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ----- src/sfir_cell.sv -----
// ----------------------------------------------------------------------------
// Stereo FIR history cell
// Holds one stereo sample; loads from the shift neighbor when a new word
// arrives and from the rotate neighbor while the filter sweeps.
// ----------------------------------------------------------------------------
module sfir_cell import sfir_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  sample_t    shift_in,
  input  sample_t    rot_in,
  output sample_t    q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (ctrl.shift) begin
      q <= shift_in;
    end else if (ctrl.rotate) begin
      q <= rot_in;
    end
  end

endmodule

// ----- src/sfir_mac.sv -----
// ----------------------------------------------------------------------------
// Stereo FIR multiply-accumulate
// Adds a mirrored sample pair, multiplies it by a half coefficient and
// accumulates; the result is rounded and saturated to Q1.15.
// ----------------------------------------------------------------------------
module sfir_mac import sfir_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  mac_ctrl_t  ctrl,
  input  sample_w_t  near_s,
  input  sample_w_t  far_s,
  input  coef_t      coef,
  output mac_stat_t  stat,
  output sample_w_t  result
);

  logic signed [PAIR_W-1:0] pair;
  coef_t                    coef_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rounded;
  logic signed [ACC_W-1:0]  shifted;
  logic                     v1;
  logic                     v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctrl.en;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    pair   <= PAIR_W'(near_s) + PAIR_W'(far_s);
    coef_q <= coef;
    prod   <= PROD_W'(pair) * PROD_W'(coef_q);
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  always_comb begin
    rounded = acc + RND_HALF;
    shifted = rounded >>> FRAC;
    if (shifted > OUT_MAX) begin
      result = OUT_MAX[SAMPLE_W-1:0];
    end else if (shifted < OUT_MIN) begin
      result = OUT_MIN[SAMPLE_W-1:0];
    end else begin
      result = shifted[SAMPLE_W-1:0];
    end
  end

  assign stat.s1_valid = v1;
  assign stat.s2_valid = v2;

endmodule

// ----- src/stereo_symmetric_fir_lowpass.sv -----
// ----------------------------------------------------------------------------
// Stereo symmetric FIR low-pass
// Two-channel linear-phase low-pass filter with 2*HALF_TAPS-1 taps and a
// Hamming-windowed sinc coefficient table.
// ----------------------------------------------------------------------------
// Usage: each word on audio_in carries one left and one right Q1.15 sample;
// for every word taken the block returns exactly one word on audio_out with
// the filtered left and right samples, rounded and saturated to Q1.15.
// The sample histories live in two rows of cells. Row "near" holds the
// HALF_TAPS newest samples, row "far" holds the centre sample and the older
// ones. A new word shifts both rows by one place. The rows then rotate in
// opposite directions, so that the ends of the two rows present one mirrored
// sample pair per cycle to a multiply-accumulate unit per channel; after
// HALF_TAPS rotations the rows are back in place.
// Sequence: a word is taken in the idle state, the sweep steps through the
// coefficient table, the MAC pipeline drains and the result is then loaded
// into the output register. The block takes no new word until that result
// has been loaded; the single MAC per channel sets this pace.
// The output register holds a result while the receiver stalls; the block
// then still takes the next word and stops only before overwriting it.
// Reset clears both histories to zero and empties the output register.
// ----------------------------------------------------------------------------
module stereo_symmetric_fir_lowpass import sfir_pkg::*; (
  input logic       clk,
  input logic       rst,
  sfir_in_if.sink   audio_in,
  sfir_out_if.source audio_out
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic             accept;
  logic             load_out;
  cell_ctrl_t       cell_ctrl;
  mac_ctrl_t        mac_ctrl;
  mac_stat_t        stat_l;
  mac_stat_t        stat_r;
  sample_t          new_s;
  sample_t          near_q [HALF_TAPS];
  sample_t          far_q  [HALF_TAPS];
  sample_w_t        res_l;
  sample_w_t        res_r;
  coef_t            coef;

  assign audio_in.ready = (state == ST_IDLE);
  assign accept         = audio_in.valid && audio_in.ready;
  assign new_s.left     = audio_in.left_in;
  assign new_s.right    = audio_in.right_in;

  assign cell_ctrl.shift  = accept;
  assign cell_ctrl.rotate = (state == ST_RUN);
  assign mac_ctrl.clear   = accept;
  assign mac_ctrl.en      = (state == ST_RUN);
  assign coef             = COEF_ROM[cnt];

  // The result only goes out once a waiting result has been taken.
  assign load_out = (state == ST_DONE) && (!audio_out.valid || audio_out.ready);

  // Near row: cell 0 takes the new word, rotation brings the last cell back to
  // the front, so the last cell shows ages HALF_TAPS-1 down to 0.
  for (genvar j = 0; j < HALF_TAPS; j++) begin : g_near
    if (j == 0) begin : g_head
      sfir_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (cell_ctrl),
        .shift_in (new_s),
        .rot_in   (near_q[HALF_TAPS-1]),
        .q        (near_q[j])
      );
    end else begin : g_body
      sfir_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (cell_ctrl),
        .shift_in (near_q[j-1]),
        .rot_in   (near_q[j-1]),
        .q        (near_q[j])
      );
    end
  end

  // Far row: cell 0 holds the centre sample, rotation runs towards cell 0,
  // so cell 0 shows ages HALF_TAPS-1 up to the oldest.
  for (genvar j = 0; j < HALF_TAPS; j++) begin : g_far
    if (j == 0) begin : g_head
      sfir_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (cell_ctrl),
        .shift_in (near_q[HALF_TAPS-2]),
        .rot_in   (far_q[1]),
        .q        (far_q[j])
      );
    end else if (j == HALF_TAPS - 1) begin : g_tail
      sfir_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (cell_ctrl),
        .shift_in (far_q[j-1]),
        .rot_in   (far_q[0]),
        .q        (far_q[j])
      );
    end else begin : g_body
      sfir_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (cell_ctrl),
        .shift_in (far_q[j-1]),
        .rot_in   (far_q[j+1]),
        .q        (far_q[j])
      );
    end
  end

  sfir_mac u_mac_left (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .near_s (near_q[HALF_TAPS-1].left),
    .far_s  (far_q[0].left),
    .coef   (coef),
    .stat   (stat_l),
    .result (res_l)
  );

  sfir_mac u_mac_right (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .near_s (near_q[HALF_TAPS-1].right),
    .far_s  (far_q[0].right),
    .coef   (coef),
    .stat   (stat_r),
    .result (res_r)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt == CNT_W'(HALF_TAPS - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last product is summed at the edge that leaves this state.
        if (!stat_l.s1_valid && stat_l.s2_valid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_RUN) begin
        cnt <= (cnt == CNT_W'(HALF_TAPS - 1)) ? '0 : cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      audio_out.valid <= 1'b0;
    end else if (load_out) begin
      audio_out.valid <= 1'b1;
    end else if (audio_out.ready) begin
      audio_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      audio_out.left_out  <= res_l;
      audio_out.right_out <= res_r;
    end
  end

  // A word taken always starts a sweep.
  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_RUN))
    else $error("accepted word did not start a sweep");

  // The tap counter stays inside the table.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (cnt <= CNT_W'(HALF_TAPS - 1)))
    else $error("tap counter out of range");

  // No product is in flight while the block waits for a word.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!stat_l.s1_valid && !stat_l.s2_valid &&
                            !stat_r.s1_valid && !stat_r.s2_valid))
    else $error("MAC pipeline busy while idle");

  // A stalled result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (audio_out.valid && !audio_out.ready) |=> $stable(audio_out.left_out) &&
                                              $stable(audio_out.right_out))
    else $error("stalled result overwritten");

endmodule
